### rtl/cplx_acc_pkg.sv
// Shared types, constants and helper functions for the complex accumulator.
// Used by cplx_acc_div and complex_arith_accumulator_top.
// No dependencies.
`default_nettype none

package cplx_acc_pkg;

    localparam int FRAC_BITS = 16;
    // one iteration per dividend bit plus one per fraction bit of the quotient
    localparam int DIV_ITER  = 64 + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_ITER);
    // exact product sums need 65 bits; one spare
    localparam int SUM_W     = 66;

    localparam logic [2:0] MUL_STEPS = 3'd4;
    localparam logic [2:0] DIV_STEPS = 3'd6;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MAC,
        ST_DIV_RE,
        ST_DIV_IM,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OPND_AR,
        OPND_AI,
        OPND_BR,
        OPND_BI
    } opnd_t;

    typedef enum logic [1:0] {
        TGT_RE,
        TGT_IM,
        TGT_DEN
    } tgt_t;

    typedef struct packed {
        opnd_t a;
        opnd_t b;
        tgt_t  tgt;
        logic  sub;
    } mac_ctl_t;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [31:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } clip_t;

    // Product schedule. Multiply uses steps 0-3, divide all six.
    //   mul: re = ar*br - ai*bi, im = ar*bi + ai*br
    //   div: re = ar*br + ai*bi, im = ai*br - ar*bi, den = br*br + bi*bi
    function automatic mac_ctl_t mac_step(input logic [2:0] step, input op_t op);
        mac_ctl_t c;
        c = '{a: OPND_AR, b: OPND_BR, tgt: TGT_RE, sub: 1'b0};
        case (step)
            3'd0:
            begin
                c = '{a: OPND_AR, b: OPND_BR, tgt: TGT_RE, sub: 1'b0};
            end
            3'd1:
            begin
                c = '{a: OPND_AI, b: OPND_BI, tgt: TGT_RE, sub: (op == OP_MUL)};
            end
            3'd2:
            begin
                c = '{a: OPND_AR, b: OPND_BI, tgt: TGT_IM, sub: (op == OP_DIV)};
            end
            3'd3:
            begin
                c = '{a: OPND_AI, b: OPND_BR, tgt: TGT_IM, sub: 1'b0};
            end
            3'd4:
            begin
                c = '{a: OPND_BR, b: OPND_BR, tgt: TGT_DEN, sub: 1'b0};
            end
            3'd5:
            begin
                c = '{a: OPND_BI, b: OPND_BI, tgt: TGT_DEN, sub: 1'b0};
            end
            default:
            begin
                c = '{a: OPND_AR, b: OPND_BR, tgt: TGT_RE, sub: 1'b0};
            end
        endcase
        return c;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic clip_t clip32(input logic [SUM_W-1:0] x);
        clip_t r;
        if (x[SUM_W-1:31] == {(SUM_W-31){x[SUM_W-1]}})
        begin
            r.val = x[31:0];
            r.sat = 1'b0;
        end
        else
        begin
            r.val = x[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/complex_arith_accumulator_top.sv
// Top level of the complex accumulator: sequencer, accumulator and result register.
// Depends on cplx_acc_pkg, cplx_acc_mul and cplx_acc_div.
`default_nettype none

// Complex accumulator in signed Q16.16. op_mode (written through cfg_wen/cfg_wdata;
// the user must write it only while idle, the block does not enforce this) picks add,
// subtract, multiply or divide; a transaction with first set loads the accumulator, any
// other combines it with the input, and every input transaction yields one output
// transaction carrying the new accumulator. One item is processed at a time and
// in_stall stays high until its result is in the output register. A load, add or
// subtract needs no multiplier pass; a multiply takes four passes through the shared
// 32x32 multiplier; a divide takes six multiplier passes and two runs of the bit-serial
// divider (real part, then imaginary part). The next transaction can be accepted while
// a result still waits on out_stall.

module complex_arith_accumulator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        first,
    input  wire logic [31:0] in_real,
    input  wire logic [31:0] in_imag,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      out_real,
    output logic [31:0]      out_imag,
    output logic             div_zero,
    output logic             saturated
);

    import cplx_acc_pkg::*;

    op_t    op_mode_reg;
    state_t state_reg, state_next;

    logic               first_reg;
    logic signed [31:0] br_reg, bi_reg;

    logic [2:0] step_reg, step_next;
    logic [2:0] n_steps;
    logic       mac_done;
    mac_ctl_t   ctl_issue, ctl_reg;
    logic       acc_en_reg, acc_en_next;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;

    logic [SUM_W-1:0] sum_re_reg, sum_im_reg, sum_den_reg;
    logic [SUM_W-1:0] prod_ext, sum_cur, sum_new;

    logic [SUM_W-1:0] a_re_ext, a_im_ext, b_re_ext, b_im_ext;
    logic [SUM_W-1:0] as_re, as_im, sh_re, sh_im;
    clip_t            clip_re, clip_im;

    logic [SUM_W-1:0] div_src, div_abs;
    logic             den_zero;

    logic [31:0] nr_reg, nr_next, ni_reg, ni_next;
    logic        dz_reg, dz_next, sat_reg, sat_next;

    logic signed [31:0] acc_real_reg, acc_imag_reg;
    logic               div_zero_reg, saturated_reg;
    logic               out_valid_reg, out_valid_next;

    logic     accept;
    logic     finish;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // ---------------- shared multiplier and product accumulation ----------------
    assign ctl_issue = mac_step(step_reg, op_mode_reg);
    assign n_steps   = (op_mode_reg == OP_DIV) ? DIV_STEPS : MUL_STEPS;
    assign mac_done  = (step_reg == n_steps + 3'd1);

    always_comb
    begin
        case (ctl_issue.a)
            OPND_AR: mul_a = acc_real_reg;
            OPND_AI: mul_a = acc_imag_reg;
            OPND_BR: mul_a = br_reg;
            OPND_BI: mul_a = bi_reg;
            default: mul_a = acc_real_reg;
        endcase
        case (ctl_issue.b)
            OPND_AR: mul_b = acc_real_reg;
            OPND_AI: mul_b = acc_imag_reg;
            OPND_BR: mul_b = br_reg;
            OPND_BI: mul_b = bi_reg;
            default: mul_b = br_reg;
        endcase
    end

    cplx_acc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign prod_ext = {{(SUM_W-64){prod[63]}}, prod};

    always_comb
    begin
        case (ctl_reg.tgt)
            TGT_RE:  sum_cur = sum_re_reg;
            TGT_IM:  sum_cur = sum_im_reg;
            TGT_DEN: sum_cur = sum_den_reg;
            default: sum_cur = sum_re_reg;
        endcase
        sum_new = ctl_reg.sub ? (sum_cur - prod_ext) : (sum_cur + prod_ext);
    end

    always_ff @(posedge clk)
    begin
        ctl_reg <= ctl_issue;
        if (accept)
        begin
            first_reg   <= first;
            br_reg      <= in_real;
            bi_reg      <= in_imag;
            sum_re_reg  <= '0;
            sum_im_reg  <= '0;
            sum_den_reg <= '0;
        end
        else if (acc_en_reg)
        begin
            case (ctl_reg.tgt)
                TGT_RE:  sum_re_reg  <= sum_new;
                TGT_IM:  sum_im_reg  <= sum_new;
                TGT_DEN: sum_den_reg <= sum_new;
                default: sum_re_reg  <= sum_new;
            endcase
        end
    end

    // ---------------- add / subtract and multiply results ----------------
    assign a_re_ext = {{(SUM_W-32){acc_real_reg[31]}}, acc_real_reg};
    assign a_im_ext = {{(SUM_W-32){acc_imag_reg[31]}}, acc_imag_reg};
    assign b_re_ext = {{(SUM_W-32){br_reg[31]}}, br_reg};
    assign b_im_ext = {{(SUM_W-32){bi_reg[31]}}, bi_reg};

    assign as_re = (op_mode_reg == OP_SUB) ? (a_re_ext - b_re_ext) : (a_re_ext + b_re_ext);
    assign as_im = (op_mode_reg == OP_SUB) ? (a_im_ext - b_im_ext) : (a_im_ext + b_im_ext);

    // floor division by 2^FRAC_BITS
    assign sh_re = $unsigned($signed(sum_re_reg) >>> FRAC_BITS);
    assign sh_im = $unsigned($signed(sum_im_reg) >>> FRAC_BITS);

    assign clip_re = clip32((state_reg == ST_EXEC) ? as_re : sh_re);
    assign clip_im = clip32((state_reg == ST_EXEC) ? as_im : sh_im);

    // ---------------- divider ----------------
    // real numerator goes in on leaving the MAC phase, imaginary one after it
    assign div_src  = (state_reg == ST_MAC) ? sum_re_reg : sum_im_reg;
    assign div_abs  = div_src[SUM_W-1] ? ('0 - div_src) : div_src;
    assign den_zero = (sum_den_reg == '0);

    cplx_acc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        acc_en_next   = 1'b0;
        nr_next       = nr_reg;
        ni_next       = ni_reg;
        dz_next       = dz_reg;
        sat_next      = sat_reg;
        finish        = 1'b0;
        div_req.start = 1'b0;
        div_req.neg   = div_src[SUM_W-1];
        div_req.mag   = div_abs[63:0];
        div_req.den   = sum_den_reg[63:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (first_reg)
                begin
                    nr_next    = br_reg;
                    ni_next    = bi_reg;
                    dz_next    = 1'b0;
                    sat_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    case (op_mode_reg)
                        OP_ADD, OP_SUB:
                        begin
                            nr_next    = clip_re.val;
                            ni_next    = clip_im.val;
                            dz_next    = 1'b0;
                            sat_next   = clip_re.sat | clip_im.sat;
                            state_next = ST_FINISH;
                        end
                        default:
                        begin
                            step_next  = '0;
                            state_next = ST_MAC;
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                acc_en_next = (step_reg < n_steps);
                if (!mac_done)
                begin
                    step_next = step_reg + 3'd1;
                end
                else if (op_mode_reg == OP_MUL)
                begin
                    nr_next    = clip_re.val;
                    ni_next    = clip_im.val;
                    dz_next    = 1'b0;
                    sat_next   = clip_re.sat | clip_im.sat;
                    state_next = ST_FINISH;
                end
                else if (den_zero)
                begin
                    // zero divisor: accumulator kept
                    nr_next    = acc_real_reg;
                    ni_next    = acc_imag_reg;
                    dz_next    = 1'b1;
                    sat_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    dz_next       = 1'b0;
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_RE;
                end
            end
            ST_DIV_RE:
            begin
                if (div_rsp.done)
                begin
                    nr_next       = div_rsp.quo;
                    sat_next      = div_rsp.sat;
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_IM;
                end
            end
            ST_DIV_IM:
            begin
                if (div_rsp.done)
                begin
                    ni_next    = div_rsp.quo;
                    sat_next   = sat_reg | div_rsp.sat;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = finish | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_mode_reg   <= OP_ADD;
            step_reg      <= '0;
            acc_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_real_reg  <= '0;
            acc_imag_reg  <= '0;
            div_zero_reg  <= 1'b0;
            saturated_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            acc_en_reg    <= acc_en_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                op_mode_reg <= op_t'(cfg_wdata);
            end
            // accumulator doubles as the output payload
            if (finish)
            begin
                acc_real_reg  <= nr_reg;
                acc_imag_reg  <= ni_reg;
                div_zero_reg  <= dz_reg;
                saturated_reg <= sat_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        nr_reg  <= nr_next;
        ni_reg  <= ni_next;
        dz_reg  <= dz_next;
        sat_reg <= sat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_real  = acc_real_reg;
    assign out_imag  = acc_imag_reg;
    assign div_zero  = div_zero_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire

### rtl/cplx_acc_mul.sv
// Shared 32x32 signed multiplier with a registered 64-bit product.
// Depends on nothing beyond its ports.
`default_nettype none

module cplx_acc_mul (
    input  wire logic               clk,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic signed [63:0]      p
);

    logic signed [63:0] p_reg;
    logic signed [63:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

### rtl/cplx_acc_div.sv
// Iterative restoring divider: (mag << FRAC_BITS) / den, one quotient bit a cycle,
// signed and saturated to 32 bits. Depends on cplx_acc_pkg.
`default_nettype none

module cplx_acc_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cplx_acc_pkg::div_req_t req,
    output cplx_acc_pkg::div_rsp_t     rsp
);

    import cplx_acc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic        neg_reg;
    logic [63:0] den_reg;
    logic [63:0] divd_reg;
    logic [63:0] rem_reg;
    logic [32:0] q_reg;
    logic        ovf_reg;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;
    logic        clip_pos;
    logic        clip_neg;
    logic [31:0] q_neg;

    // remainder stays below den, so 64 bits hold it between steps
    assign trial = {rem_reg, divd_reg[63]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == DIV_CNT_W'(DIV_ITER - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg  <= req.neg;
            den_reg  <= req.den;
            divd_reg <= req.mag;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            // zeros shift in below the dividend for the fraction bits
            divd_reg <= {divd_reg[62:0], 1'b0};
            rem_reg  <= ge ? diff[63:0] : trial[63:0];
            ovf_reg  <= ovf_reg | q_reg[32];
            q_reg    <= {q_reg[31:0], ge};
        end
    end

    // magnitude 2^31 is still in range when negative
    assign clip_pos = ovf_reg | q_reg[32] | q_reg[31];
    assign clip_neg = ovf_reg | q_reg[32] | (q_reg[31] & (q_reg[30:0] != '0));
    assign q_neg    = 32'd0 - q_reg[31:0];

    always_comb
    begin
        rsp.done = done_reg;
        if (neg_reg)
        begin
            rsp.sat = clip_neg;
            rsp.quo = clip_neg ? 32'h8000_0000 : q_neg;
        end
        else
        begin
            rsp.sat = clip_pos;
            rsp.quo = clip_pos ? 32'h7FFF_FFFF : q_reg[31:0];
        end
    end

endmodule

`default_nettype wire
